// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL; they compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== hdl/tcw_pkg.sv =====
package tcw_pkg;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int WORD_W = 16;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFF_W  = 11;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h0F;
  localparam int                TAB_STOP   = 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } tcw_op_e;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_RESP
  } tcw_state_e;

  typedef struct packed {
    logic capture;      // latch the incoming item
    logic exec;         // apply the operation to cursor / memory
    logic ptr_zero;
    logic ptr_step;
    logic scroll_move;  // copy cell ptr+COLUMNS down to ptr
    logic fill_write;   // write blank at ptr
    logic fill_reset;   // blank uses the reset attribute
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            need_scroll;
    logic            scroll_end;
    logic            fill_end;
    logic            out_free;
  } tcw_sts_t;

endpackage

// ===== hdl/tcw_ram.sv =====
module tcw_ram #(
  parameter  int Width = 16,
  parameter  int Depth = 2000,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tcw_ctrl.sv =====
`include "assert_macros.svh"

module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t cmd_o
);

  import tcw_pkg::*;

  tcw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WIPE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WIPE: begin
        if (sts_i.fill_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.op == OP_CLEAR) begin
          state_d = ST_FILL;
        end else if (sts_i.op == OP_PUT && sts_i.need_scroll) begin
          state_d = ST_SCROLL;
        end else if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SCROLL: begin
        if (sts_i.scroll_end) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (sts_i.fill_end) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_WIPE: begin
        cmd_o.fill_write = 1'b1;
        cmd_o.fill_reset = 1'b1;
        cmd_o.ptr_step   = !sts_i.fill_end;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec     = 1'b1;
        cmd_o.ptr_zero = 1'b1;
        if (sts_i.op != OP_CLEAR && !(sts_i.op == OP_PUT && sts_i.need_scroll)) begin
          cmd_o.out_load = sts_i.out_free;
        end
      end
      ST_SCROLL: begin
        cmd_o.scroll_move = 1'b1;
        cmd_o.ptr_step    = !sts_i.scroll_end;
      end
      ST_FILL: begin
        cmd_o.fill_write = 1'b1;
        cmd_o.ptr_step   = !sts_i.fill_end;
      end
      ST_RESP: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: ;
    endcase
  end

  `ASSERT_PROP(a_load_free, clk_i, rst_ni, cmd_o.out_load |-> sts_i.out_free, "result load over a pending result")
  `ASSERT_PROP(a_wipe_once, clk_i, rst_ni, state_q != ST_WIPE |=> state_q != ST_WIPE, "reset wipe re-entered")

endmodule

// ===== hdl/tcw_dp.sv =====
`include "assert_macros.svh"

module tcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcw_pkg::tcw_cmd_t             cmd_i,
  output tcw_pkg::tcw_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    cfg_attr_i,
  input  logic [tcw_pkg::OP_W-1:0]      operation_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]     cell_index_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tcw_pkg::WORD_W-1:0]    cell_word_o,
  output logic [tcw_pkg::COL_W-1:0]     cursor_column_o,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row_o,
  output logic [tcw_pkg::OFF_W-1:0]     cursor_offset_o
);

  import tcw_pkg::*;

  localparam int CellCount = COLUMNS * ROWS;
  localparam int ScrollEnd = (ROWS - 1) * COLUMNS;
  localparam int AddrW     = $clog2(CellCount);
  localparam int ColW      = $clog2(COLUMNS);
  localparam int RowW      = $clog2(ROWS);

  logic [ColW-1:0]   col_q, col_d, col_nxt;
  logic [RowW-1:0]   row_q, row_d, row_nxt;
  logic [ColW:0]     col_step;
  logic [RowW:0]     row_step;
  logic [CHAR_W-1:0] attr_q;
  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] char_q;
  logic [AddrW-1:0]  idx_q;
  logic              in_range_q;
  logic [AddrW-1:0]  ptr_q;
  logic [AddrW-1:0]  off_cur, off_d;
  logic              printable, need_scroll;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic              out_valid_q;
  logic [WORD_W-1:0] word_q;
  logic [COL_W-1:0]  ocol_q;
  logic [ROW_W-1:0]  orow_q;
  logic [OFF_W-1:0]  ooff_q;

  assign printable = char_q >= CHAR_SPACE;
  assign off_cur   = AddrW'(row_q) * AddrW'(COLUMNS) + AddrW'(col_q);

  // cursor movement for a put
  always_comb begin
    col_step = {1'b0, col_q};
    row_step = {1'b0, row_q};
    if (char_q == CHAR_BS && col_q != '0) begin
      col_step = {1'b0, col_q} - (ColW+1)'(1);
    end
    if (char_q == CHAR_TAB) begin
      col_step = ({1'b0, col_q} + (ColW+1)'(TAB_STOP)) & ~(ColW+1)'(TAB_STOP - 1);
    end
    if (char_q == CHAR_CR) begin
      col_step = '0;
    end
    if (char_q == CHAR_LF) begin
      col_step = '0;
      row_step = row_step + (RowW+1)'(1);
    end
    if (printable) begin
      col_step = col_step + (ColW+1)'(1);
    end
    if (col_step >= (ColW+1)'(COLUMNS)) begin
      col_step = '0;
      row_step = row_step + (RowW+1)'(1);
    end
    need_scroll = row_step == (RowW+1)'(ROWS);
    col_nxt     = col_step[ColW-1:0];
    row_nxt     = need_scroll ? RowW'(ROWS - 1) : row_step[RowW-1:0];
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.exec && op_q == OP_PUT) begin
      col_d = col_nxt;
      row_d = row_nxt;
    end
    if (cmd_i.exec && op_q == OP_CLEAR) begin
      col_d = '0;
      row_d = '0;
    end
  end

  assign off_d = AddrW'(row_d) * AddrW'(COLUMNS) + AddrW'(col_d);

  // cell memory port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = {attr_q, CHAR_SPACE};
    if (cmd_i.exec && op_q == OP_PUT && printable) begin
      ram_we    = 1'b1;
      ram_waddr = off_cur;
      ram_wdata = {attr_q, char_q};
    end
    if (cmd_i.scroll_move && ptr_q != '0) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q - AddrW'(1);
      ram_wdata = ram_rdata;
    end
    if (cmd_i.fill_write) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q;
      ram_wdata = cmd_i.fill_reset ? {RESET_ATTR, CHAR_SPACE} : {attr_q, CHAR_SPACE};
    end
  end

  always_comb begin
    if (cmd_i.scroll_move) begin
      ram_raddr = ptr_q + AddrW'(COLUMNS);
    end else if (cmd_i.capture) begin
      ram_raddr = AddrW'(cell_index_i);
    end else begin
      ram_raddr = idx_q;
    end
  end

  tcw_ram #(
    .Width (WORD_W),
    .Depth (CellCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= RESET_ATTR;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) attr_q <= cfg_attr_i;
      if (cmd_i.ptr_zero) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_step) begin
        ptr_q <= ptr_q + AddrW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= operation_i;
      char_q     <= char_code_i;
      idx_q      <= AddrW'(cell_index_i);
      in_range_q <= 32'(cell_index_i) < 32'(CellCount);
    end
    if (cmd_i.out_load) begin
      word_q <= (op_q == OP_READ && in_range_q) ? ram_rdata : '0;
      ocol_q <= COL_W'(col_d);
      orow_q <= ROW_W'(row_d);
      ooff_q <= OFF_W'(off_d);
    end
  end

  assign sts_o.op          = op_q;
  assign sts_o.need_scroll = need_scroll;
  assign sts_o.scroll_end  = ptr_q == AddrW'(ScrollEnd);
  assign sts_o.fill_end    = ptr_q == AddrW'(CellCount - 1);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign cell_word_o     = word_q;
  assign cursor_column_o = ocol_q;
  assign cursor_row_o    = orow_q;
  assign cursor_offset_o = ooff_q;

  `ASSERT_PROP(a_cursor_range, clk_i, rst_ni, (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS), "cursor out of screen")
  `ASSERT_PROP(a_scroll_span, clk_i, rst_ni, cmd_i.scroll_move |-> 32'(ptr_q) <= ScrollEnd, "scroll pointer overran")

endmodule

// ===== hdl/text_console_writer.sv =====
`include "assert_macros.svh"

// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (colour
// attribute in the high byte, character in the low byte) held in one
// single-port-write cell RAM with a registered read. Operation 0 puts a
// character at the cursor (backspace, tab, CR and LF move the cursor, other
// control codes are ignored, the rest are stored in the current colour),
// operation 1 blanks the screen and homes the cursor, operation 2 reads one
// cell (an index past the screen reads as 0). Each input transfer gives
// exactly one output transfer carrying the cursor after the operation and
// its linear offset row*COLUMNS+column, ready for the CRT cursor registers.
// Per item: a put that does not scroll, a read or the unused code executes,
// then waits in the result state only while the previous result is held; a
// clear executes, blanks every cell in the fill sweep and hands off its
// result; a put that scrolls also runs the scroll sweep and then blanks the
// bottom row in the fill sweep. The cell RAM takes one write per cycle: a
// scroll copies each of the (ROWS-1)*COLUMNS upper cells one per cycle.
// After reset the RAM is wiped to white-on-black spaces with in_ready_o
// low; the attribute register accepts writes throughout, and its write
// takes effect on the next character or blank stored after the wipe. The
// result sits in an output register, so a new item may be taken while the
// previous result still waits for out_ready_i.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // attribute write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcw_pkg::CHAR_W-1:0]    cfg_text_attribute_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcw_pkg::OP_W-1:0]      operation_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]     cell_index_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcw_pkg::WORD_W-1:0]    cell_word_o,
  output logic [tcw_pkg::COL_W-1:0]     cursor_column_o,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row_o,
  output logic [tcw_pkg::OFF_W-1:0]     cursor_offset_o
);

  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  // The attribute register never stalls a transfer.
  assign cfg_ready_o = 1'b1;

  // Sequencer: owns the reset wipe, the scroll/clear sweeps and the
  // result hand-off; the datapath only acts on its commands.
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Cursor, attribute, sweep pointer, cell RAM and result register.
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_attr_i      (cfg_text_attribute_i),
    .operation_i     (operation_i),
    .char_code_i     (char_code_i),
    .cell_index_i    (cell_index_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .cell_word_o     (cell_word_o),
    .cursor_column_o (cursor_column_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_offset_o (cursor_offset_o)
  );

  // One item in flight: the cycle after a transfer nothing more is taken.
  `ASSERT_PROP(a_single_item, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "second item taken while busy")

endmodule
